[hw/rtl/lsbg_pkg.sv]
// Shared types, register indexes, reset values and budget floors for the governor.
package lsbg_pkg;

    localparam int BUD_W     = 16;   // task budget width
    localparam int LAT_W     = 24;   // latency / runtime width
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 24;
    localparam int NUM_BUD   = 5;    // 16-bit budgets; slice runtime handled apart

    localparam int RELAX_WINDOWS_DEF = 4;

    typedef enum logic [1:0] {
        LVL_NORMAL      = 2'd0,
        LVL_CONSTRAINED = 2'd1,
        LVL_EMERGENCY   = 2'd2
    } lsbg_level_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WALK      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASYNC     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFERRED  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLETE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EMERGENCY = 4'd7;

    // reset values, budgets in index order
    localparam logic [BUD_W-1:0] BUD_RST [NUM_BUD] = '{16'd256, 16'd8, 16'd64, 16'd64, 16'd128};
    localparam logic [LAT_W-1:0] SLICE_RST     = 24'd2000;
    localparam logic [LAT_W-1:0] TARGET_RST    = 24'd10000;
    localparam logic [LAT_W-1:0] EMERGENCY_RST = 24'd50000;

    // floors: constrained / emergency
    localparam logic [BUD_W-1:0] BUD_MIN_CON [NUM_BUD] = '{16'd32, 16'd2, 16'd4, 16'd4, 16'd8};
    localparam logic [BUD_W-1:0] BUD_MIN_EMR [NUM_BUD] = '{16'd16, 16'd1, 16'd2, 16'd1, 16'd4};
    localparam logic [LAT_W-1:0] SLICE_MIN_CON = 24'd500;
    localparam logic [LAT_W-1:0] SLICE_MIN_EMR = 24'd250;

endpackage

[hw/rtl/load_state_budget_governor.sv]
// Load-state budget governor top level: config registers, input and result registers.
//
// One measurement window per s_axis transfer; one result per window on m_axis.
// The control latency is the larger of the window's p99 latency and oldest-task
// age. It drives a three-level load state (normal / constrained / emergency):
// reaching the target or the emergency threshold escalates at once, while
// RELAX_WINDOWS consecutive healthy windows drop one level. Each result carries
// six effective budgets scaled for the new level, the level, the control
// latency and a level-changed flag. Timing: a window is taken into the input
// register, and its result moves into the output register once that register
// is empty or being read; throughput is one window per clock unless m_tready
// stalls it. The level update and budget scaling are one combinational pass
// between the two registers. Configuration writes (cfg_wr_en) take effect the
// next cycle and must only be issued while no window is in flight; indexes
// above 7 are dropped, as are data bits above a register's width.
module load_state_budget_governor
    import lsbg_pkg::*;
#(
    parameter int RELAX_WINDOWS = RELAX_WINDOWS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [23:0] tail_latency_us, [47:24] oldest_age_us
    input  logic [47:0]          s_tdata,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] walk_budget_out, [31:16] parallel_budget_out, [47:32] async_budget_out,
    // [63:48] deferred_budget_out, [79:64] completion_budget_out,
    // [103:80] slice_runtime_out, [105:104] load_level, [129:106] control_latency_us,
    // [130] level_changed, [135:131] zero
    output logic [135:0]         m_tdata
);

    localparam int CNT_W = $clog2(RELAX_WINDOWS + 1);

    // configuration
    logic [BUD_W-1:0] bud_cfg_reg [NUM_BUD];
    logic [LAT_W-1:0] slice_cfg_reg;
    logic [LAT_W-1:0] target_cfg_reg;
    logic [LAT_W-1:0] emergency_cfg_reg;

    // governor state
    lsbg_level_t      level_reg;
    logic [CNT_W-1:0] count_reg;
    lsbg_level_t      level_next;
    logic [CNT_W-1:0] count_next;

    // input stage
    logic             in_valid_reg;
    logic [LAT_W-1:0] tail_reg;
    logic [LAT_W-1:0] age_reg;
    logic [LAT_W-1:0] ctl;

    // output stage
    logic             out_valid_reg;
    logic [BUD_W-1:0] bud_out_reg [NUM_BUD];
    logic [LAT_W-1:0] slice_out_reg;
    lsbg_level_t      level_out_reg;
    logic [LAT_W-1:0] ctl_out_reg;
    logic             changed_out_reg;

    logic [BUD_W-1:0] bud_next [NUM_BUD];
    logic [LAT_W-1:0] slice_next;

    logic advance;   // window moves from input register to output register

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign ctl      = (tail_reg > age_reg) ? tail_reg : age_reg;

    // config writes; unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUD; i++) begin
                bud_cfg_reg[i] <= BUD_RST[i];
            end
            slice_cfg_reg     <= SLICE_RST;
            target_cfg_reg    <= TARGET_RST;
            emergency_cfg_reg <= EMERGENCY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_WALK:      bud_cfg_reg[0]    <= cfg_wr_data[BUD_W-1:0];
                CFG_PARALLEL:  bud_cfg_reg[1]    <= cfg_wr_data[BUD_W-1:0];
                CFG_ASYNC:     bud_cfg_reg[2]    <= cfg_wr_data[BUD_W-1:0];
                CFG_DEFERRED:  bud_cfg_reg[3]    <= cfg_wr_data[BUD_W-1:0];
                CFG_COMPLETE:  bud_cfg_reg[4]    <= cfg_wr_data[BUD_W-1:0];
                CFG_SLICE:     slice_cfg_reg     <= cfg_wr_data[LAT_W-1:0];
                CFG_TARGET:    target_cfg_reg    <= cfg_wr_data[LAT_W-1:0];
                CFG_EMERGENCY: emergency_cfg_reg <= cfg_wr_data[LAT_W-1:0];
                default: ;
            endcase
        end
    end

    lsbg_level #(
        .RELAX_WINDOWS (RELAX_WINDOWS),
        .CNT_W         (CNT_W)
    ) u_level (
        .ctl           (ctl),
        .target_cfg    (target_cfg_reg),
        .emergency_cfg (emergency_cfg_reg),
        .level_cur     (level_reg),
        .count_cur     (count_reg),
        .level_nxt     (level_next),
        .count_nxt     (count_next)
    );

    // budgets follow the level this window ends in
    for (genvar g = 0; g < NUM_BUD; g++) begin : g_bud
        lsbg_budget #(
            .W       (BUD_W),
            .MIN_CON (BUD_MIN_CON[g]),
            .MIN_EMR (BUD_MIN_EMR[g])
        ) u_bud (
            .cfg    (bud_cfg_reg[g]),
            .level  (level_next),
            .budget (bud_next[g])
        );
    end

    lsbg_budget #(
        .W       (LAT_W),
        .MIN_CON (SLICE_MIN_CON),
        .MIN_EMR (SLICE_MIN_EMR)
    ) u_slice (
        .cfg    (slice_cfg_reg),
        .level  (level_next),
        .budget (slice_next)
    );

    // control: valids and governor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= LVL_NORMAL;
            count_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                level_reg     <= level_next;
                count_reg     <= count_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tail_reg <= s_tdata[23:0];
            age_reg  <= s_tdata[47:24];
        end
        if (advance) begin
            for (int i = 0; i < NUM_BUD; i++) begin
                bud_out_reg[i] <= bud_next[i];
            end
            slice_out_reg   <= slice_next;
            level_out_reg   <= level_next;
            ctl_out_reg     <= ctl;
            changed_out_reg <= (level_next != level_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, changed_out_reg, ctl_out_reg, level_out_reg, slice_out_reg,
                       bud_out_reg[4], bud_out_reg[3], bud_out_reg[2], bud_out_reg[1],
                       bud_out_reg[0]};

endmodule

[hw/rtl/lsbg_level.sv]
// Load level update: escalation on threshold crossings, relaxation after healthy windows.
module lsbg_level
    import lsbg_pkg::*;
#(
    parameter int RELAX_WINDOWS = RELAX_WINDOWS_DEF,
    parameter int CNT_W         = $clog2(RELAX_WINDOWS + 1)
) (
    input  logic [LAT_W-1:0] ctl,
    input  logic [LAT_W-1:0] target_cfg,
    input  logic [LAT_W-1:0] emergency_cfg,
    input  lsbg_level_t      level_cur,
    input  logic [CNT_W-1:0] count_cur,
    output lsbg_level_t      level_nxt,
    output logic [CNT_W-1:0] count_nxt
);

    logic [LAT_W-1:0] slo;
    logic [LAT_W:0]   slo_p1;
    logic [LAT_W:0]   emer;
    logic [LAT_W+3:0] ctl_x10;
    logic [LAT_W+3:0] slo_x7;
    logic             healthy;
    logic [CNT_W-1:0] count_inc;

    assign slo    = (target_cfg == '0) ? LAT_W'(1) : target_cfg;
    assign slo_p1 = {1'b0, slo} + (LAT_W+1)'(1);
    assign emer   = ({1'b0, emergency_cfg} > slo_p1) ? {1'b0, emergency_cfg} : slo_p1;

    // ctl <= floor(slo*7/10)  <=>  10*ctl <= 7*slo
    assign ctl_x10 = {1'b0, ctl, 3'b000} + {3'b000, ctl, 1'b0};
    assign slo_x7  = {1'b0, slo, 3'b000} - {4'b0000, slo};

    assign healthy   = (level_cur == LVL_EMERGENCY) ? (ctl <= slo) : (ctl_x10 <= slo_x7);
    assign count_inc = count_cur + CNT_W'(1);

    always_comb begin
        level_nxt = level_cur;
        count_nxt = '0;
        if ({1'b0, ctl} >= emer) begin
            level_nxt = LVL_EMERGENCY;
        end else if (ctl >= slo) begin
            if (level_cur == LVL_NORMAL) begin
                level_nxt = LVL_CONSTRAINED;
            end
        end else if (level_cur != LVL_NORMAL && healthy) begin
            if (32'(count_inc) >= RELAX_WINDOWS) begin
                level_nxt = (level_cur == LVL_EMERGENCY) ? LVL_CONSTRAINED : LVL_NORMAL;
            end else begin
                count_nxt = count_inc;
            end
        end
    end

endmodule

[hw/rtl/lsbg_budget.sv]
// One effective budget: floor at 1, scale down by level, clamp to floor and configured value.
module lsbg_budget
    import lsbg_pkg::*;
#(
    parameter int         W       = BUD_W,
    parameter logic [W-1:0] MIN_CON = '1,
    parameter logic [W-1:0] MIN_EMR = '1
) (
    input  logic [W-1:0] cfg,
    input  lsbg_level_t  level,
    output logic [W-1:0] budget
);

    logic [W-1:0] c;
    logic [W-1:0] s;
    logic [W-1:0] floor_v;
    logic [W-1:0] lifted;

    assign c = (cfg == '0) ? W'(1) : cfg;

    always_comb begin
        s       = c >> 1;
        floor_v = MIN_CON;
        if (level == LVL_EMERGENCY) begin
            s       = c >> 2;
            floor_v = MIN_EMR;
        end
        if (s == '0) begin
            s = W'(1);
        end
        lifted = (s > floor_v) ? s : floor_v;
        budget = c;
        if (level != LVL_NORMAL && lifted < c) begin
            budget = lifted;
        end
    end

endmodule

[bench/tb_load_state_budget_governor.sv]
// Testbench for the load-state budget governor: directed table, then random windows vs. a predictor.
`timescale 1ns / 100ps

module tb_load_state_budget_governor;
    import lsbg_pkg::*;

    localparam int RELAX_WINDOWS     = RELAX_WINDOWS_DEF;
    localparam int WINDOWS_PER_SETUP = 90;     // 9 setups -> about 800 random windows
    localparam int DRAIN_CYCLES      = 4;      // two-stage pipe plus margin
    localparam int MAX_REPORTS       = 10;
    localparam logic [23:0] LAT_MAX  = 24'hFFFFFF;

    // Indexes outside the register map; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    // Latency bands for the random windows, relative to the live thresholds.
    typedef enum int {
        BAND_HEALTHY,   // at or below the recovery point
        BAND_MARGIN,    // above recovery, below target
        BAND_OVER,      // target up to just below emergency
        BAND_EMER,      // at or above emergency
        BAND_EDGE,      // exactly on a threshold or one off
        BAND_NOISE      // both fields fully random
    } lat_band_t;

    // One result transfer, fields as they sit in m_tdata; bud[0] is the walk budget.
    typedef struct packed {
        logic                changed;
        logic [23:0]         ctl;
        lsbg_level_t         level;
        logic [23:0]         slice;
        logic [4:0][15:0]    bud;
    } gov_result_t;

    // Directed stimulus row: either a register write or a window.
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DAT_W-1:0]  data;
        logic [23:0]           tail;
        logic [23:0]           age;
        bit                    typed;   // want holds a hand-written result
        gov_result_t           want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CFG_DAT_W-1:0] cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    // [23:0] tail_latency_us, [47:24] oldest_age_us
    logic [47:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // [79:0] five 16-bit budgets (walk first), [103:80] slice_runtime_out,
    // [105:104] load_level, [129:106] control_latency_us, [130] level_changed
    logic [135:0]         m_tdata;

    // Predictor state: a private copy of the registers and the governor state.
    logic [23:0]          cfg_val [8];
    lsbg_level_t          gov_level;
    int                   healthy_run;

    gov_result_t          expected_q [$];
    stim_row_t            stim_rows [$];
    int                   fail_count = 0;
    int                   snd_idle;     // percent of cycles the sender holds off
    int                   rcv_idle;     // percent of cycles the receiver stalls
    lat_band_t            lat_band;

    load_state_budget_governor #(
        .RELAX_WINDOWS(RELAX_WINDOWS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Healthy-window ceiling: the target itself in emergency, 70% of it otherwise.
    function automatic int unsigned recovery_point(input int unsigned slo, input lsbg_level_t lvl);
        return (lvl == LVL_EMERGENCY) ? slo : (slo * 7) / 10;
    endfunction

    function automatic int unsigned target_floor();
        return (cfg_val[CFG_TARGET] == 0) ? 1 : cfg_val[CFG_TARGET];
    endfunction

    // Emergency threshold is kept at least target+1; may be 2^24, which nothing reaches.
    function automatic int unsigned emergency_floor(input int unsigned slo);
        return (cfg_val[CFG_EMERGENCY] > slo + 1) ? cfg_val[CFG_EMERGENCY] : slo + 1;
    endfunction

    // Shrink a budget by the shift, then clamp between its floor and its configured value.
    function automatic logic [23:0] scale_budget(input logic [23:0] c, input int sh,
                                                 input logic [23:0] min_v);
        logic [23:0] s;
        logic [23:0] v;
        s = c >> sh;
        if (s == 0)
            s = 24'd1;
        v = (s > min_v) ? s : min_v;
        return (v < c) ? v : c;
    endfunction

    function automatic gov_result_t predict_window(input logic [23:0] tail, input logic [23:0] age);
        gov_result_t  r;
        logic [23:0]  ctl;
        logic [23:0]  c;
        logic [23:0]  v;
        int unsigned  slo;
        int unsigned  emer;
        lsbg_level_t  prev;
        bit           emr;
        ctl  = (tail > age) ? tail : age;
        slo  = target_floor();
        emer = emergency_floor(slo);
        prev = gov_level;

        if (ctl >= emer) begin
            gov_level   = LVL_EMERGENCY;
            healthy_run = 0;
        end else if (ctl >= slo) begin
            if (gov_level == LVL_NORMAL)
                gov_level = LVL_CONSTRAINED;
            healthy_run = 0;
        end else if (gov_level != LVL_NORMAL && ctl <= recovery_point(slo, gov_level)) begin
            healthy_run++;
            if (healthy_run >= RELAX_WINDOWS) begin
                gov_level   = (gov_level == LVL_EMERGENCY) ? LVL_CONSTRAINED : LVL_NORMAL;
                healthy_run = 0;
            end
        end else begin
            healthy_run = 0;
        end

        emr = (gov_level == LVL_EMERGENCY);
        for (int i = 0; i < NUM_BUD; i++) begin
            c = (cfg_val[i] == 0) ? 24'd1 : cfg_val[i];
            v = c;
            if (gov_level != LVL_NORMAL)
                v = scale_budget(c, emr ? 2 : 1, 24'(emr ? BUD_MIN_EMR[i] : BUD_MIN_CON[i]));
            r.bud[i] = v[15:0];
        end
        c = (cfg_val[CFG_SLICE] == 0) ? 24'd1 : cfg_val[CFG_SLICE];
        r.slice   = (gov_level == LVL_NORMAL) ? c
                  : scale_budget(c, emr ? 2 : 1, emr ? SLICE_MIN_EMR : SLICE_MIN_CON);
        r.level   = gov_level;
        r.ctl     = ctl;
        r.changed = (gov_level != prev);
        return r;
    endfunction

    function automatic gov_result_t typed_result(input logic [15:0] w, p, a, d, cm,
                                                 input logic [23:0] sl, input lsbg_level_t lvl,
                                                 input logic [23:0] ctl, input logic chg);
        gov_result_t r;
        r.bud     = {cm, d, a, p, w};
        r.slice   = sl;
        r.level   = lvl;
        r.ctl     = ctl;
        r.changed = chg;
        return r;
    endfunction

    function automatic string show(input gov_result_t r);
        return $sformatf("walk=%0d par=%0d async=%0d defer=%0d compl=%0d slice=%0d lvl=%0d ctl=%0d chg=%0d",
                         r.bud[0], r.bud[1], r.bud[2], r.bud[3], r.bud[4], r.slice,
                         r.level, r.ctl, r.changed);
    endfunction

    // ------------------------------------------------------------------
    // Drivers: everything changes on the falling edge
    // ------------------------------------------------------------------

    // Receiver back-pressure, one decision per cycle.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= rcv_idle);

    // Register write; the predictor copy follows at the write edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        if (idx <= CFG_EMERGENCY)
            cfg_val[idx] = (idx < CFG_SLICE) ? (data & 24'h00FFFF) : data;
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Pipe empty: no window pending and all results back, plus the pipe depth.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One window transfer. valid stays high straight into the next window
    // unless the sender decides to hold off first.
    task automatic send_window(input logic [23:0] tail, input logic [23:0] age,
                               input bit typed, input gov_result_t want);
        gov_result_t pred;
        while ($urandom_range(99) < snd_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {age, tail};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pred = predict_window(tail, age);
        expected_q.push_back(typed ? want : pred);
    endtask

    function automatic logic [23:0] pick_between(input int unsigned lo, input int unsigned hi);
        if (hi > LAT_MAX)
            hi = LAT_MAX;
        if (lo > hi)
            lo = hi;
        return 24'($urandom_range(hi, lo));
    endfunction

    // Random window. The band is sticky (a new one a quarter of the time), so
    // runs of healthy windows long enough to relax the level come up often.
    task automatic send_random_window();
        int unsigned slo;
        int unsigned emer;
        int unsigned rec;
        logic [23:0] ctl;
        logic [23:0] other;
        if ($urandom_range(3) == 0)
            lat_band = lat_band_t'($urandom_range(BAND_NOISE));
        slo  = target_floor();
        emer = emergency_floor(slo);
        rec  = recovery_point(slo, gov_level);
        case (lat_band)
            BAND_HEALTHY: ctl = pick_between(0, rec);
            BAND_MARGIN:  ctl = pick_between(rec + 1, slo - 1);
            BAND_OVER:    ctl = pick_between(slo, emer - 1);
            BAND_EMER:    ctl = pick_between(emer, LAT_MAX);
            BAND_EDGE: begin
                case ($urandom_range(5))
                    0: ctl = pick_between(rec, rec);
                    1: ctl = pick_between(rec + 1, rec + 1);
                    2: ctl = pick_between(slo - 1, slo - 1);
                    3: ctl = pick_between(slo, slo);
                    4: ctl = pick_between(emer - 1, emer - 1);
                    default: ctl = pick_between(emer, emer);
                endcase
            end
            default: begin
                send_window(24'($urandom), 24'($urandom), 1'b0, '0);
                return;
            end
        endcase
        other = pick_between(0, 32'(ctl));
        if ($urandom_range(1))
            send_window(ctl, other, 1'b0, '0);
        else
            send_window(other, ctl, 1'b0, '0);
    endtask

    // New register setup between phases. Setup 0 is all zero, setup 4 all ones;
    // the rest are random, with wide data on 16-bit registers now and then.
    task automatic apply_setup(input int k);
        logic [23:0] tgt;
        logic [23:0] val;
        wait_idle();
        tgt = '0;
        for (int i = CFG_WALK; i <= CFG_EMERGENCY; i++) begin
            if (k == 0)
                val = '0;
            else if (k == 4)
                val = LAT_MAX;
            else if (i <= CFG_SLICE) begin
                case ($urandom_range(3))
                    0: val = 24'($urandom);
                    1: val = 24'($urandom_range(40));
                    2: val = 24'($urandom_range(700));
                    default: val = 24'($urandom_range(65535));
                endcase
            end else if (i == CFG_TARGET) begin
                case ($urandom_range(4))
                    0: val = 24'($urandom_range(3));
                    1: val = 24'($urandom_range(200));
                    2: val = 24'($urandom_range(60000));
                    3: val = 24'($urandom);
                    default: val = TARGET_RST;
                endcase
                tgt = val;
            end else begin
                case ($urandom_range(3))
                    0: val = '0;
                    1: val = pick_between(32'(tgt), 32'(tgt) * 4 + 20);
                    2: val = 24'($urandom);
                    default: val = 24'(tgt + 1);
                endcase
            end
            write_reg(CFG_IDX_W'(i), val);
        end
        // a stray write outside the map must leave everything alone
        write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)), 24'($urandom));
        end_writes();
    endtask

    // Directed table builders.
    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        stim_rows.push_back('{is_cfg: 1'b1, idx: idx, data: data, tail: '0, age: '0,
                              typed: 1'b0, want: '0});
    endtask

    task automatic add_win(input logic [23:0] tail, input logic [23:0] age);
        stim_rows.push_back('{is_cfg: 1'b0, idx: '0, data: '0, tail: tail, age: age,
                              typed: 1'b0, want: '0});
    endtask

    task automatic add_win_typed(input logic [23:0] tail, input logic [23:0] age,
                                 input gov_result_t want);
        stim_rows.push_back('{is_cfg: 1'b0, idx: '0, data: '0, tail: tail, age: age,
                              typed: 1'b1, want: want});
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // ------------------------------------------------------------------
    // Result checker: sampled on the rising edge, oldest expectation first
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        gov_result_t got;
        gov_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.bud     = m_tdata[79:0];
            got.slice   = m_tdata[103:80];
            got.level   = lsbg_level_t'(m_tdata[105:104]);
            got.ctl     = m_tdata[129:106];
            got.changed = m_tdata[130];
            if (expected_q.size() == 0) begin
                note_failure($sformatf("unexpected result: %s", show(got)));
            end else begin
                want = expected_q.pop_front();
                if (got !== want)
                    note_failure($sformatf("mismatch:\n  exp %s\n  got %s", show(want), show(got)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit writing;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        snd_idle     = 9;
        rcv_idle     = 79;
        lat_band     = BAND_HEALTHY;
        writing      = 1'b0;
        for (int i = 0; i < NUM_BUD; i++)
            cfg_val[i] = 24'(BUD_RST[i]);
        cfg_val[CFG_SLICE]     = SLICE_RST;
        cfg_val[CFG_TARGET]    = TARGET_RST;
        cfg_val[CFG_EMERGENCY] = EMERGENCY_RST;
        gov_level   = LVL_NORMAL;
        healthy_run = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset registers: target 10000, emergency 50000, constrained recovery 7000.
        add_win_typed(24'd0, 24'd0,
                      typed_result(16'd256, 16'd8, 16'd64, 16'd64, 16'd128, 24'd2000,
                                   LVL_NORMAL, 24'd0, 1'b0));
        add_win(24'd10000, 24'd0);          // exactly on target: to constrained
        add_win(24'd0, 24'd50000);          // age alone hits emergency
        add_win(24'd9999, 24'd0);           // healthy run broken by a target hit
        add_win(24'd0, 24'd9999);
        add_win(24'd12000, 24'd0);
        add_win(24'd9999, 24'd0);           // four healthy: down to constrained
        add_win(24'd0, 24'd9999);
        add_win(24'd9999, 24'd9999);
        add_win(24'd0, 24'd9999);
        add_win(24'd7000, 24'd0);
        add_win(24'd7001, 24'd0);           // one above recovery but below target clears the run
        add_win(24'd0, 24'd7000);           // four healthy: back to normal
        add_win(24'd7000, 24'd0);
        add_win(24'd0, 24'd7000);
        add_win(24'd7000, 24'd6999);
        add_win(LAT_MAX, LAT_MAX);

        // All registers zero: target clamps to 1, emergency to 2, budgets to 1.
        for (int i = CFG_WALK; i <= CFG_EMERGENCY; i++)
            add_cfg(CFG_IDX_W'(i), '0);
        add_cfg(CFG_UNUSED_LO, LAT_MAX);
        add_cfg(CFG_UNUSED_HI, LAT_MAX);
        add_win_typed(24'd0, 24'd0,
                      typed_result(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 24'd1,
                                   LVL_EMERGENCY, 24'd0, 1'b0));
        add_win(24'd1, 24'd0);
        add_win(24'd0, 24'd2);

        // All ones: wide data on 16-bit registers, emergency threshold out of reach.
        for (int i = CFG_WALK; i <= CFG_EMERGENCY; i++)
            add_cfg(CFG_IDX_W'(i), LAT_MAX);
        add_win(LAT_MAX, 24'd0);
        add_win(24'hFFFFFE, 24'hFFFFFE);
        add_win(24'hAAAAAA, 24'h555555);
        add_win(24'h555555, 24'hAAAAAA);
        add_win(24'd0, 24'h800000);

        foreach (stim_rows[n]) begin
            if (stim_rows[n].is_cfg) begin
                if (!writing) begin
                    wait_idle();
                    writing = 1'b1;
                end
                write_reg(stim_rows[n].idx, stim_rows[n].data);
            end else begin
                if (writing) begin
                    end_writes();
                    writing = 1'b0;
                end
                send_window(stim_rows[n].tail, stim_rows[n].age,
                            stim_rows[n].typed, stim_rows[n].want);
            end
        end

        // Random part: three idling profiles, three register setups each.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin snd_idle = 9;  rcv_idle = 79; end
                1: begin snd_idle = 79; rcv_idle = 9;  end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            for (int k = 0; k < 3; k++) begin
                apply_setup(ph * 3 + k);
                repeat (WINDOWS_PER_SETUP) send_random_window();
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lsbg_pkg.sv
hw/rtl/lsbg_level.sv
hw/rtl/lsbg_budget.sv
hw/rtl/load_state_budget_governor.sv
bench/tb_load_state_budget_governor.sv
